FILE: src/efr_pkg.sv
// Package: framing constants, receiver mode and result kind types for the deframer.
`default_nettype none

package efr_pkg;

  localparam int MAX_FRAME_LEN = 4096;

  localparam int BYTE_W      = 8;
  localparam int KIND_W      = 2;
  localparam int INDEX_W     = 12;
  localparam int FRAME_LEN_W = 13;
  localparam int CNT_W       = $clog2(MAX_FRAME_LEN + 1);

  localparam logic [BYTE_W-1:0] FLAG_START = 8'h12;
  localparam logic [BYTE_W-1:0] FLAG_END   = 8'h13;
  localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'h7D;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_FRAME = 2'd1,
    MODE_ESC   = 2'd2
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_END     = 2'd1,
    KIND_ABORT   = 2'd2
  } kind_t;

endpackage

`default_nettype wire

FILE: src/efr_if.sv
// Interfaces: received-byte channel and deframed result channel.
`default_nettype none

interface efr_in_if import efr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efr_out_if import efr_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [KIND_W-1:0]      out_kind;
  logic [BYTE_W-1:0]      out_byte;
  logic [INDEX_W-1:0]     byte_index;
  logic [FRAME_LEN_W-1:0] frame_length;

  modport source (output valid, output out_kind, output out_byte, output byte_index,
                  output frame_length, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input byte_index,
                  input frame_length, output ready);
endinterface

`default_nettype wire

FILE: src/escaped_flag_frame_receiver.sv
// Top level: byte-stuffed frame receiver (start/end flags, escape byte).
// A result enters the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle; input stalls only while a held result is not taken.
// Bytes that cause no result (idle bytes, escape) are consumed without an output slot.
// Reset (sync, active low): mode idle, payload count zero, output register empty.
`default_nettype none

module escaped_flag_frame_receiver import efr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  efr_in_if.sink    in_ch,
  efr_out_if.source out_ch
);

  mode_t                  mode_r, mode_nxt, eff_mode;
  logic [CNT_W-1:0]       count_r, count_nxt, eff_count;
  logic                   ovf;
  logic                   in_acc;

  logic                   res_valid;
  kind_t                  res_kind;
  logic [BYTE_W-1:0]      res_byte;
  logic [INDEX_W-1:0]     res_index;
  logic [FRAME_LEN_W-1:0] res_len;

  logic                   out_valid_r;
  kind_t                  out_kind_r;
  logic [BYTE_W-1:0]      out_byte_r;
  logic [INDEX_W-1:0]     out_index_r;
  logic [FRAME_LEN_W-1:0] out_len_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // A full frame aborts on the next byte, which is then handled as an idle byte.
  assign ovf       = (count_r >= CNT_W'(MAX_FRAME_LEN));
  assign eff_mode  = ovf ? MODE_IDLE : mode_r;
  assign eff_count = ovf ? '0 : count_r;

  // next state
  always_comb begin
    mode_nxt  = eff_mode;
    count_nxt = eff_count;
    unique case (eff_mode)
      MODE_IDLE: begin
        if (in_ch.rx_byte == FLAG_START) mode_nxt = MODE_FRAME;
      end
      MODE_FRAME: begin
        if (in_ch.rx_byte == FLAG_END) begin
          mode_nxt  = MODE_IDLE;
          count_nxt = '0;
        end else if (in_ch.rx_byte == ESC_BYTE) begin
          mode_nxt = MODE_ESC;
        end else begin
          count_nxt = eff_count + CNT_W'(1);
        end
      end
      MODE_ESC: begin
        mode_nxt  = MODE_FRAME;
        count_nxt = eff_count + CNT_W'(1);
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase
  end

  // result
  always_comb begin
    res_valid = ovf;
    res_kind  = KIND_ABORT;
    res_byte  = '0;
    res_index = '0;
    res_len   = '0;
    unique case (eff_mode)
      MODE_IDLE: ;
      MODE_FRAME: begin
        if (in_ch.rx_byte == FLAG_END) begin
          res_valid = 1'b1;
          res_kind  = KIND_END;
          res_len   = FRAME_LEN_W'(eff_count);
        end else if (in_ch.rx_byte != ESC_BYTE) begin
          res_valid = 1'b1;
          res_kind  = KIND_PAYLOAD;
          res_byte  = in_ch.rx_byte;
          res_index = INDEX_W'(eff_count);
        end
      end
      MODE_ESC: begin
        res_valid = 1'b1;
        res_kind  = KIND_PAYLOAD;
        res_byte  = in_ch.rx_byte;
        res_index = INDEX_W'(eff_count);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_kind_r  <= res_kind;
      out_byte_r  <= res_byte;
      out_index_r <= res_index;
      out_len_r   <= res_len;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_kind     = out_kind_r;
  assign out_ch.out_byte     = out_byte_r;
  assign out_ch.byte_index   = out_index_r;
  assign out_ch.frame_length = out_len_r;

  // count only lives inside a frame
  a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE) |-> (count_r == '0))
    else $error("payload count nonzero while idle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_FRAME_LEN))
    else $error("payload count past maximum frame length");

  a_end_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !ovf && mode_r == MODE_FRAME && in_ch.rx_byte == FLAG_END) |=>
    (out_valid_r && out_kind_r == KIND_END && mode_r == MODE_IDLE && count_r == '0))
    else $error("end flag did not close the frame");

  a_overflow_abort: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && ovf) |=> (out_valid_r && out_kind_r == KIND_ABORT))
    else $error("full frame not aborted");

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Testbench for the escaped-flag frame receiver: directed table, random framed traffic, overflow.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import efr_pkg::*;

  typedef struct packed {
    kind_t                  kind;
    logic [BYTE_W-1:0]      data;
    logic [INDEX_W-1:0]     index;
    logic [FRAME_LEN_W-1:0] length;
  } frame_result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    bit                typed;
    bit                has;
    frame_result_t     res;
  } stim_row_t;

  localparam int RANDOM_ITEMS = 1050;
  localparam int IDLE_PCT     = 14;

  logic clk;
  logic rst_n;

  efr_in_if  in_ch ();
  efr_out_if out_ch ();

  escaped_flag_frame_receiver dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // deframer state as the predictor sees it
  mode_t          rx_state;
  logic [CNT_W:0] frame_count;

  frame_result_t pending_results[$];
  bit            no_idle;
  int            mismatch_count;
  int            sent_items;
  int            payload_seen;
  int            ends_seen;
  int            aborts_seen;

  // Typed rows carry their expectation; the rest go through the predictor.
  stim_row_t directed_rows [23] = '{
    '{FLAG_END,   1'b1, 1'b0, '0},  // flags and data ignored while idle
    '{ESC_BYTE,   1'b1, 1'b0, '0},
    '{8'h00,      1'b1, 1'b0, '0},
    '{8'hFF,      1'b1, 1'b0, '0},
    '{FLAG_START, 1'b1, 1'b0, '0},
    '{FLAG_END,   1'b1, 1'b1, '{KIND_END, 8'h00, 12'd0, 13'd0}},  // empty frame
    '{FLAG_START, 1'b1, 1'b0, '0},
    '{8'h00,      1'b1, 1'b1, '{KIND_PAYLOAD, 8'h00, 12'd0, 13'd0}},
    '{8'hFF,      1'b1, 1'b1, '{KIND_PAYLOAD, 8'hFF, 12'd1, 13'd0}},
    '{FLAG_START, 1'b0, 1'b0, '0},  // repeated start inside a frame is data
    '{ESC_BYTE,   1'b0, 1'b0, '0},
    '{FLAG_END,   1'b0, 1'b0, '0},
    '{ESC_BYTE,   1'b0, 1'b0, '0},
    '{FLAG_START, 1'b0, 1'b0, '0},
    '{ESC_BYTE,   1'b0, 1'b0, '0},
    '{ESC_BYTE,   1'b0, 1'b0, '0},  // escaped escape
    '{8'hA5,      1'b0, 1'b0, '0},
    '{FLAG_END,   1'b1, 1'b1, '{KIND_END, 8'h00, 12'd0, 13'd7}},
    '{8'h5A,      1'b1, 1'b0, '0},
    '{FLAG_START, 1'b0, 1'b0, '0},
    '{ESC_BYTE,   1'b0, 1'b0, '0},
    '{FLAG_END,   1'b0, 1'b0, '0},
    '{FLAG_END,   1'b1, 1'b1, '{KIND_END, 8'h00, 12'd0, 13'd1}}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advances the predicted state by one byte; returns 1 when a result is due.
  function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output frame_result_t r);
    bit hit;
    hit = 1'b0;
    r   = '0;
    if (frame_count >= MAX_FRAME_LEN) begin
      r.kind      = KIND_ABORT;
      hit         = 1'b1;
      rx_state    = MODE_IDLE;
      frame_count = '0;
    end
    case (rx_state)
      MODE_IDLE: begin
        if (b == FLAG_START) rx_state = MODE_FRAME;
      end
      MODE_FRAME: begin
        if (b == FLAG_END) begin
          r           = '0;
          r.kind      = KIND_END;
          r.length    = FRAME_LEN_W'(frame_count);
          hit         = 1'b1;
          rx_state    = MODE_IDLE;
          frame_count = '0;
        end else if (b == ESC_BYTE) begin
          rx_state = MODE_ESC;
        end else begin
          r       = '0;
          r.kind  = KIND_PAYLOAD;
          r.data  = b;
          r.index = INDEX_W'(frame_count);
          hit     = 1'b1;
          frame_count++;
        end
      end
      MODE_ESC: begin
        r        = '0;
        r.kind   = KIND_PAYLOAD;
        r.data   = b;
        r.index  = INDEX_W'(frame_count);
        hit      = 1'b1;
        frame_count++;
        rx_state = MODE_FRAME;
      end
      default: rx_state = MODE_IDLE;
    endcase
    return hit;
  endfunction

  // Biased toward the framing codes so they show up often.
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(7))
      0:       return FLAG_START;
      1:       return FLAG_END;
      2:       return ESC_BYTE;
      default: return BYTE_W'($urandom_range(255));
    endcase
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
                           input bit typed_has = 1'b0, input frame_result_t typed_res = '0);
    frame_result_t r;
    bit            has;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    has = deframe_byte(b, r);
    if (typed) begin
      has = typed_has;
      r   = typed_res;
    end
    if (has) pending_results.push_back(r);
    sent_items++;
  endtask

  // Start flag, len payload bytes (end flag and escape always stuffed), then closer.
  task automatic send_frame(input int unsigned len, input logic [BYTE_W-1:0] closer);
    logic [BYTE_W-1:0] b;
    send_byte(FLAG_START);
    for (int unsigned i = 0; i < len; i++) begin
      b = pick_byte();
      if (b == FLAG_END || b == ESC_BYTE || $urandom_range(9) == 0) send_byte(ESC_BYTE);
      send_byte(b);
    end
    send_byte(closer);
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  initial begin : result_monitor
    frame_result_t exp_r;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected transaction: kind %0d byte %02h index %0d length %0d",
                 out_ch.out_kind, out_ch.out_byte, out_ch.byte_index, out_ch.frame_length);
          mismatch_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_ch.out_kind !== exp_r.kind) begin
            $error("out_kind: expected %0d, got %0d", exp_r.kind, out_ch.out_kind);
            mismatch_count++;
          end
          if (out_ch.out_byte !== exp_r.data) begin
            $error("out_byte: expected %02h, got %02h", exp_r.data, out_ch.out_byte);
            mismatch_count++;
          end
          if (out_ch.byte_index !== exp_r.index) begin
            $error("byte_index: expected %0d, got %0d", exp_r.index, out_ch.byte_index);
            mismatch_count++;
          end
          if (out_ch.frame_length !== exp_r.length) begin
            $error("frame_length: expected %0d, got %0d", exp_r.length, out_ch.frame_length);
            mismatch_count++;
          end
          case (exp_r.kind)
            KIND_PAYLOAD: payload_seen++;
            KIND_END:     ends_seen++;
            default:      aborts_seen++;
          endcase
        end
      end
      out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin : stimulus
    int random_start;
    int sel;
    int unsigned len;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    rx_state       = MODE_IDLE;
    frame_count    = '0;
    no_idle        = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].has,
                directed_rows[i].res);
    hold_until_drained();

    random_start = sent_items;
    while (sent_items - random_start < RANDOM_ITEMS) begin
      no_idle = (sent_items - random_start > 400) && (sent_items - random_start < 650);
      sel = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(12);
      if (sel < 72) begin
        send_frame(len, FLAG_END);
      end else if (sel < 84) begin
        send_frame(len, pick_byte());  // random closer: the frame may close or be left open
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(pick_byte());
      end
    end
    no_idle = 1'b0;
    hold_until_drained();

    // longest frame that closes, then full frames overflowed by start flag, escape, random byte
    send_frame(MAX_FRAME_LEN - 1, FLAG_END);
    send_frame(MAX_FRAME_LEN, FLAG_START);
    send_byte(8'h00);
    send_byte(FLAG_END);
    no_idle = 1'b1;
    send_frame(MAX_FRAME_LEN, ESC_BYTE);
    no_idle = 1'b0;
    send_frame(MAX_FRAME_LEN, pick_byte());
    send_frame(3, FLAG_END);

    hold_until_drained();
    repeat (8) @(posedge clk);
    $display("run covered %0d input bytes: %0d payload bytes, %0d frame ends, %0d aborts",
             sent_items, payload_seen, ends_seen, aborts_seen);
    $display("including empty, escaped-flag, full-length and overflowed frames");
    if (mismatch_count == 0) begin
      $display("escaped_flag_frame_receiver regression: pass");
    end else begin
      $display("escaped_flag_frame_receiver regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("escaped_flag_frame_receiver regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
